[design/aes_pkg.sv]
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, constants and byte functions for the aes-128 encryption core
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned RkIdxW    = 4;

  typedef logic [127:0] blk_t;

  typedef enum logic {
    CFG_KEY_UPPER = 1'b0,
    CFG_KEY_LOWER = 1'b1
  } cfg_idx_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block sits in bits 127-8i downto 120-8i
  function automatic logic [7:0] get_byte(input blk_t b, input int unsigned i);
    return b[127 - 8*i -: 8];
  endfunction

  function automatic blk_t sub_shift(input blk_t s);
    blk_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(4*c + r) -: 8] = SBOX[get_byte(s, 4*((c + r) % 4) + r)];
      end
    end
    return t;
  endfunction

  function automatic blk_t mix(input blk_t s);
    blk_t t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      t[127 - 32*c -: 8]  = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      t[119 - 32*c -: 8]  = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      t[111 - 32*c -: 8]  = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      t[103 - 32*c -: 8]  = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return t;
  endfunction

  function automatic logic [7:0] rcon(input logic [RkIdxW-1:0] n);
    logic [7:0] r;
    r = 8'h01;
    for (int i = 1; i < 10; i++) begin
      if (i < n) r = xt(r);
    end
    return r;
  endfunction

  // next round key from previous, n is the index of the new key (1..10)
  function automatic blk_t next_key(input blk_t k, input logic [RkIdxW-1:0] n);
    logic [31:0] w0, w1, w2, w3, tw;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    tw = {SBOX[w3[23:16]] ^ rcon(n), SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ tw;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

[design/aes_round.sv]
// ----------------------------------------------------------------------------
// aes_round
// one registered cipher round with its round key derived alongside
// ----------------------------------------------------------------------------
module aes_round #(
  parameter int unsigned RoundIdx = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_in,
  input  aes_pkg::blk_t st_in,
  input  aes_pkg::blk_t key_in,
  output logic          vld_out,
  output aes_pkg::blk_t st_out,
  output aes_pkg::blk_t key_out
);
  import aes_pkg::*;

  logic vld_r;
  blk_t st_r, key_r, key_nxt, st_nxt, ss;

  always_comb begin
    key_nxt = next_key(key_in, RkIdxW'(RoundIdx));
    ss      = sub_shift(st_in);
    if (RoundIdx == NumRounds) begin
      st_nxt = ss ^ key_nxt;
    end else begin
      st_nxt = mix(ss) ^ key_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    st_r  <= st_nxt;
    key_r <= key_nxt;
  end

  assign vld_out = vld_r;
  assign st_out  = st_r;
  assign key_out = key_r;
endmodule

[design/aes128_block_encrypt.sv]
// ----------------------------------------------------------------------------
// aes128_block_encrypt
// pipelined aes-128 ecb encryption, one block per cycle
//
//   channel  ports                                   handshake
//   in       in_plain_upper, in_plain_lower          start & !busy
//   out      out_cipher_upper, out_cipher_lower      out_strobe, one cycle
//   cfg      cfg_we, cfg_index, cfg_data             cfg_we
//
// a word accepted at one edge passes through one stage for the initial key
// addition and one per round, each round stage also deriving its round key.
// busy stays low, so a word may enter every cycle.
// synchronous reset clears only the valid bits and the two configured key registers.
// ----------------------------------------------------------------------------
module aes128_block_encrypt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_plain_upper,
  input  logic [63:0] in_plain_lower,
  output logic        out_strobe,
  output logic [63:0] out_cipher_upper,
  output logic [63:0] out_cipher_lower,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);
  import aes_pkg::*;

  logic [63:0] key_upper_r, key_lower_r;
  logic        vld0_r;
  blk_t        st0_r, key0_r;

  logic vld [NumRounds+1];
  blk_t st  [NumRounds+1];
  blk_t rk  [NumRounds+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_upper_r <= '0;
      key_lower_r <= '0;
      vld0_r      <= 1'b0;
    end else begin
      vld0_r <= start;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_KEY_UPPER: key_upper_r <= cfg_data;
          CFG_KEY_LOWER: key_lower_r <= cfg_data;
          default: ;
        endcase
      end
    end
    st0_r  <= {in_plain_upper, in_plain_lower} ^ {key_upper_r, key_lower_r};
    key0_r <= {key_upper_r, key_lower_r};
  end

  assign vld[0] = vld0_r;
  assign st[0]  = st0_r;
  assign rk[0]  = key0_r;

  for (genvar g = 1; g <= NumRounds; g++) begin : g_round
    aes_round #(.RoundIdx(g)) u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .vld_in  (vld[g-1]),
      .st_in   (st[g-1]),
      .key_in  (rk[g-1]),
      .vld_out (vld[g]),
      .st_out  (st[g]),
      .key_out (rk[g])
    );
  end

  assign busy             = 1'b0;
  assign out_strobe       = vld[NumRounds];
  assign out_cipher_upper = st[NumRounds][127:64];
  assign out_cipher_lower = st[NumRounds][63:0];
endmodule

[tb/tb_aes128_block_encrypt.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aes128_block_encrypt
// self-checking bench for the aes-128 ecb core: blocks are sent with random
// gaps under several keys, each ciphertext word is checked in order against
// a local cipher computation that builds its own s-box and key schedule
// ----------------------------------------------------------------------------
module tb_aes128_block_encrypt;
  import aes_pkg::*;

  localparam int CycleLimit = 400000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [63:0] in_plain_upper;
  logic [63:0] in_plain_lower;
  logic        out_strobe;
  logic [63:0] out_cipher_upper;
  logic [63:0] out_cipher_lower;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_data;

  logic [7:0]   sub_byte [256];
  logic [127:0] cipher_key;
  logic [127:0] cipher_q[$];
  int           err_cnt;
  int           cycle_cnt;

  aes128_block_encrypt uut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] gmul2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gmul2(a);
    end
    return p;
  endfunction

  // s-box from the field inverse (x^254) and the affine map
  task automatic build_sub_byte();
    logic [7:0] b, v;
    for (int x = 0; x < 256; x++) begin
      b = x[7:0];
      v = 8'h01;
      for (int k = 0; k < 7; k++) begin
        b = gmul(b, b);
        v = gmul(v, b);
      end
      if (x == 0) v = 8'h00;
      sub_byte[x] = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
                    ^ {v[3:0], v[7:4]} ^ 8'h63;
    end
  endtask

  function automatic logic [127:0] encrypt_block(input logic [127:0] key,
                                                 input logic [127:0] plain);
    logic [7:0] rk[176];
    logic [7:0] st[16];
    logic [7:0] t[16];
    logic [7:0] w[4];
    logic [7:0] h, rc, a0, a1, a2, a3;
    logic [127:0] res;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127 - 8*i -: 8];
      st[i] = plain[127 - 8*i -: 8];
    end
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) w[j] = rk[i - 4 + j];
      if (i % 16 == 0) begin
        h = w[0];
        w[0] = sub_byte[w[1]] ^ rc;
        w[1] = sub_byte[w[2]];
        w[2] = sub_byte[w[3]];
        w[3] = sub_byte[h];
        rc = gmul2(rc);
      end
      for (int j = 0; j < 4; j++) rk[i + j] = rk[i - 16 + j] ^ w[j];
    end
    for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[4*c + r] = sub_byte[st[4*((c + r) % 4) + r]];
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          t[4*c]   = gmul2(a0) ^ gmul2(a1) ^ a1 ^ a2 ^ a3;
          t[4*c+1] = a0 ^ gmul2(a1) ^ gmul2(a2) ^ a2 ^ a3;
          t[4*c+2] = a0 ^ a1 ^ gmul2(a2) ^ gmul2(a3) ^ a3;
          t[4*c+3] = gmul2(a0) ^ a0 ^ a1 ^ a2 ^ gmul2(a3);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = t[i] ^ rk[16*rnd + i];
    end
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = st[i];
    return res;
  endfunction

  task automatic write_key_reg(input cfg_idx_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_KEY_UPPER) cipher_key[127:64] = val;
    else cipher_key[63:0] = val;
  endtask

  task automatic load_key(input logic [127:0] key);
    write_key_reg(CFG_KEY_UPPER, key[127:64]);
    write_key_reg(CFG_KEY_LOWER, key[63:0]);
  endtask

  // start stays high through back-to-back words
  task automatic send_block(input logic [127:0] plain, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    start          <= 1'b1;
    in_plain_upper <= plain[127:64];
    in_plain_lower <= plain[63:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    cipher_q.push_back(encrypt_block(cipher_key, plain));
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (cipher_q.size() > 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  function automatic logic [127:0] rand_block();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic int rand_gap();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
  endfunction

  task automatic test_reset_key();
    send_block('0, 0);
    send_block({128{1'b1}}, 0);
    drain();
  endtask

  task automatic test_known_vector();
    load_key(128'h000102030405060708090a0b0c0d0e0f);
    send_block(128'h00112233445566778899aabbccddeeff, 0);
    drain();
    load_key(128'h2b7e151628aed2a6abf7158809cf4f3c);
    send_block(128'h3243f6a8885a308d313198a2e0370734, 0);
    drain();
  endtask

  task automatic test_extremes();
    logic [127:0] keys[3];
    keys[0] = '0;
    keys[1] = {128{1'b1}};
    keys[2] = {64'h8000000000000001, 64'h8000000000000001};
    foreach (keys[k]) begin
      load_key(keys[k]);
      send_block('0, 0);
      send_block({128{1'b1}}, 0);
      send_block({1'b1, 127'b0}, 1);
      send_block(128'h1, 0);
      send_block({64'h5555555555555555, 64'haaaaaaaaaaaaaaaa}, 0);
      drain();
    end
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 6; ph++) begin
      load_key(rand_block());
      for (int i = 0; i < 250; i++) begin
        send_block(rand_block(), (ph == 2) ? 0 : rand_gap());
      end
      drain();
    end
  endtask

  // one key register at a time, the other keeps its value
  task automatic test_partial_key_update();
    write_key_reg(CFG_KEY_LOWER, {$urandom, $urandom});
    for (int i = 0; i < 20; i++) send_block(rand_block(), rand_gap());
    drain();
    write_key_reg(CFG_KEY_UPPER, {$urandom, $urandom});
    for (int i = 0; i < 20; i++) send_block(rand_block(), rand_gap());
    drain();
  endtask

  always @(posedge clk) begin
    logic [127:0] exp_c;
    if (rst_n && out_strobe) begin
      if (cipher_q.size() == 0) begin
        $error("unexpected word: cipher %h%h", out_cipher_upper, out_cipher_lower);
        err_cnt++;
      end else begin
        exp_c = cipher_q.pop_front();
        if (out_cipher_upper !== exp_c[127:64]) begin
          $error("cipher_upper expected %h actual %h", exp_c[127:64], out_cipher_upper);
          err_cnt++;
        end
        if (out_cipher_lower !== exp_c[63:0]) begin
          $error("cipher_lower expected %h actual %h", exp_c[63:0], out_cipher_lower);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("aes128_block_encrypt verification failed");
      $finish;
    end
  end

  initial begin
    err_cnt        = 0;
    cycle_cnt      = 0;
    cipher_key     = '0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_plain_upper = '0;
    in_plain_lower = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_KEY_UPPER;
    cfg_data       = '0;
    build_sub_byte();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_key();
    test_known_vector();
    test_extremes();
    test_random_traffic();
    test_partial_key_update();
    if (cipher_q.size() != 0) begin
      $error("%0d words never arrived", cipher_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("aes128_block_encrypt verification clean");
    end else begin
      $display("aes128_block_encrypt verification failed");
    end
    $finish;
  end

endmodule
